/* design/utfd_pkg.sv */
// Shared types and byte-class constants for the UTF-8 to UCS-2 stream decoder.
// Used by the input stage, the decode core, the output stage and the top level.
package utfd_pkg;

    // End kinds reported with each result item
    localparam logic [1:0] END_CONT  = 2'd0;
    localparam logic [1:0] END_NORM  = 2'd1;
    localparam logic [1:0] END_STRAY = 2'd2;
    localparam logic [1:0] END_CAP   = 2'd3;

    // Lead and continuation byte boundaries
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD5_MIN = 8'hF8;
    localparam logic [7:0] LEAD6_MIN = 8'hFC;

    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // One input item
    typedef struct packed {
        logic       last_byte;
        logic [7:0] byte_in;
    } item_t;

    // One result item
    typedef struct packed {
        logic [1:0]  end_kind;
        logic        malformed;
        logic        unit_valid;
        logic [15:0] code_unit;
    } result_t;

endpackage

/* design/utfd_in_stage.sv */
// Input register stage: captures one item from the slave channel.
// Depends on utfd_pkg for the item type.
module utfd_in_stage import utfd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_take
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    // Free when empty or when the held item is consumed this cycle
    assign s_tready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* design/utfd_core.sv */
// Decode core: running string state, capacity register and the combinational
// byte decode that turns the held item into at most one result. Uses utfd_pkg.
module utfd_core import utfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_take,
    input  logic        res_room,
    output logic        res_valid,
    output result_t     res
);

    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] partial_reg, partial_next;
    logic        seq_bad_reg, seq_bad_next;
    logic [15:0] units_reg, units_next;
    logic        halted_reg, halted_next;
    logic [15:0] cap_reg;

    logic        has_res;
    logic        fin_req;
    logic [15:0] fin_unit;
    logic        fin_bad;
    logic [7:0]  b;
    logic        last;
    logic        cont_bad;
    logic [15:0] shifted;
    logic [2:0]  left_dec;

    assign b        = item.byte_in;
    assign last     = item.last_byte;
    assign cont_bad = ((b & CONT_MASK) != CONT_TAG);
    assign shifted  = {partial_reg[9:0], b[5:0]};
    assign left_dec = bytes_left_reg - 3'd1;

    // Consume when the output side can take a result, or none is produced
    assign item_take = item_valid && (res_room || !has_res);
    assign res_valid = item_valid && has_res && res_room;

    // Byte decode and state update
    always_comb begin
        bytes_left_next = bytes_left_reg;
        partial_next    = partial_reg;
        seq_bad_next    = seq_bad_reg;
        units_next      = units_reg;
        halted_next     = halted_reg;
        has_res         = 1'b0;
        res             = '0;
        fin_req         = 1'b0;
        fin_unit        = '0;
        fin_bad         = 1'b0;

        // Classify the byte against the running sequence
        if (halted_reg) begin
            if (last) begin
                halted_next = 1'b0;
                units_next  = '0;
            end
        end else if (bytes_left_reg == 3'd0) begin
            priority if (b < CONT_TAG) begin
                fin_req  = 1'b1;
                fin_unit = {8'h00, b};
            end else if (b < LEAD2_MIN) begin
                // stray continuation byte in lead position
                has_res      = 1'b1;
                res.end_kind = END_STRAY;
                if (last) begin
                    units_next = '0;
                end else begin
                    halted_next = 1'b1;
                end
            end else begin
                seq_bad_next = 1'b0;
                priority if (b < LEAD3_MIN) begin
                    bytes_left_next = 3'd1;
                    partial_next    = {11'd0, b[4:0]};
                end else if (b < LEAD4_MIN) begin
                    bytes_left_next = 3'd2;
                    partial_next    = {12'd0, b[3:0]};
                end else if (b < LEAD5_MIN) begin
                    bytes_left_next = 3'd3;
                    partial_next    = {13'd0, b[2:0]};
                end else if (b < LEAD6_MIN) begin
                    bytes_left_next = 3'd4;
                    partial_next    = {14'd0, b[1:0]};
                end else begin
                    bytes_left_next = 3'd5;
                    partial_next    = {15'd0, b[0]};
                end
                if (last) begin
                    fin_req = 1'b1;
                    fin_bad = 1'b1;
                end
            end
        end else begin
            seq_bad_next    = seq_bad_reg || cont_bad;
            partial_next    = shifted;
            bytes_left_next = left_dec;
            if (left_dec == 3'd0) begin
                fin_req  = 1'b1;
                fin_unit = shifted;
                fin_bad  = seq_bad_reg || cont_bad;
            end else if (last) begin
                fin_req = 1'b1;
                fin_bad = 1'b1;
            end
        end

        // Completed sequence: emit it or stop on capacity
        if (fin_req) begin
            has_res         = 1'b1;
            bytes_left_next = '0;
            partial_next    = '0;
            seq_bad_next    = 1'b0;
            if (units_reg >= cap_reg) begin
                res.end_kind = END_CAP;
                if (last) begin
                    units_next = '0;
                end else begin
                    halted_next = 1'b1;
                end
            end else begin
                res.code_unit  = fin_bad ? 16'd0 : fin_unit;
                res.unit_valid = 1'b1;
                res.malformed  = fin_bad;
                res.end_kind   = last ? END_NORM : END_CONT;
                units_next     = last ? 16'd0 : units_reg + 16'd1;
            end
        end
    end

    // State registers advance only on a consumed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            partial_reg    <= '0;
            seq_bad_reg    <= 1'b0;
            units_reg      <= '0;
            halted_reg     <= 1'b0;
        end else if (item_take) begin
            bytes_left_reg <= bytes_left_next;
            partial_reg    <= partial_next;
            seq_bad_reg    <= seq_bad_next;
            units_reg      <= units_next;
            halted_reg     <= halted_next;
        end
    end

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

`ifndef SYNTHESIS
    // While discarding, no sequence can be in flight
    a_halt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> (bytes_left_reg == 3'd0 && partial_reg == 16'd0 && !seq_bad_reg))
        else $error("halted with a sequence in flight");

    // Sequences are at most six bytes
    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= 3'd5)
        else $error("bytes_left out of range");

    // Stop results carry no unit
    a_stop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res.unit_valid) |->
        ((res.end_kind == END_STRAY || res.end_kind == END_CAP)
         && res.code_unit == 16'd0 && !res.malformed))
        else $error("stop result carries a unit");

    // A malformed unit is zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.malformed) |-> (res.unit_valid && res.code_unit == 16'd0))
        else $error("malformed unit not zero");

    // After a last byte is consumed the string state is clear
    a_string_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && last) |=> (bytes_left_reg == 3'd0 && units_reg == 16'd0 && !halted_reg))
        else $error("string state not cleared at end of string");
`endif

endmodule

/* design/utfd_out_stage.sv */
// Output register stage: holds one result item for the master channel.
// Depends on utfd_pkg for the result type.
module utfd_out_stage import utfd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    res_room,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Room when empty or the held item leaves this cycle
    assign res_room = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_room) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_room && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

/* design/utf8_to_ucs2_stream_decoder_unit.sv */
// UTF-8 to UCS-2 stream decoder. Accepts one byte per cycle and sustains one
// item per cycle in both directions while the master side is ready; a byte is
// held in the input register, then decoded in the core and its result registered
// in the output register, from which it is presented on the master side. Bytes
// that finish no character give no result, except a stray continuation byte and a last byte that cuts a sequence short.
// The capacity register is written with cfg_wr_en.
// Top level: ties together utfd_in_stage, utfd_core and utfd_out_stage (utfd_pkg).
module utf8_to_ucs2_stream_decoder_unit import utfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // output_capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] byte_in
    input  logic        s_tlast,      // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [15:0] code_unit
    output logic [3:0]  m_tuser       // [0] unit_valid, [1] malformed, [3:2] end_kind
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    logic    res_valid;
    logic    res_room;
    result_t res;
    result_t m_res;

    assign s_item.byte_in   = s_tdata;
    assign s_item.last_byte = s_tlast;

    utfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    utfd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .res_room    (res_room),
        .res_valid   (res_valid),
        .res         (res)
    );

    utfd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_room  (res_room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = m_res.code_unit;
    assign m_tuser = {m_res.end_kind, m_res.malformed, m_res.unit_valid};

endmodule

/* test/utf8_to_ucs2_stream_decoder_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to UCS-2 stream decoder: drives byte items,
// predicts each decoded unit in-bench and checks results. Needs utfd_pkg and the top level.
module utf8_to_ucs2_stream_decoder_unit_test import utfd_pkg::*;;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_WAIT  = 4;
    localparam int PHASE_ITEMS  = 350;
    localparam int CFG_INTERVAL = 40;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;

    // Decoder state mirror
    logic [15:0] cap_limit;
    logic [2:0]  cont_left;
    logic [15:0] unit_acc;
    logic        unit_bad;
    logic [15:0] unit_count;
    logic        discarding;

    result_t     pending_units[$];
    logic [7:0]  str_bytes[$];

    int unsigned items_sent  = 0;
    int unsigned mismatches  = 0;
    int unsigned quiet_count = 0;
    int          hold_left   = 0;
    logic        hold_req     = 1'b0;
    logic        hold_started = 1'b0;
    int          send_gap_pct = 0;
    int          recv_gap_pct = 0;

    utf8_to_ucs2_stream_decoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ---------------- prediction ----------------

    task automatic clear_string();
        cont_left  = 3'd0;
        unit_acc   = 16'h0000;
        unit_bad   = 1'b0;
        unit_count = 16'h0000;
        discarding = 1'b0;
    endtask

    // A sequence is complete: emit its unit or stop on capacity
    task automatic close_unit(input logic [15:0] unit, input logic bad, input logic last);
        cont_left = 3'd0;
        unit_acc  = 16'h0000;
        unit_bad  = 1'b0;
        if (unit_count >= cap_limit) begin
            pending_units.push_back({END_CAP, 1'b0, 1'b0, 16'h0000});
            if (last) clear_string();
            else discarding = 1'b1;
        end else begin
            pending_units.push_back({(last ? END_NORM : END_CONT), bad, 1'b1,
                                     (bad ? 16'h0000 : unit)});
            unit_count = unit_count + 16'd1;
            if (last) clear_string();
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        if (discarding) begin
            // rest of a stopped string is dropped; last byte rearms
            if (last) clear_string();
        end else if (cont_left == 3'd0) begin
            if (b < CONT_TAG) begin
                close_unit({8'h00, b}, 1'b0, last);
            end else if (b < LEAD2_MIN) begin
                // continuation byte where a lead belongs
                pending_units.push_back({END_STRAY, 1'b0, 1'b0, 16'h0000});
                if (last) clear_string();
                else discarding = 1'b1;
            end else begin
                if (b < LEAD3_MIN) begin
                    cont_left = 3'd1;
                    unit_acc  = {11'd0, b[4:0]};
                end else if (b < LEAD4_MIN) begin
                    cont_left = 3'd2;
                    unit_acc  = {12'd0, b[3:0]};
                end else if (b < LEAD5_MIN) begin
                    cont_left = 3'd3;
                    unit_acc  = {13'd0, b[2:0]};
                end else if (b < LEAD6_MIN) begin
                    cont_left = 3'd4;
                    unit_acc  = {14'd0, b[1:0]};
                end else begin
                    cont_left = 3'd5;
                    unit_acc  = {15'd0, b[0]};
                end
                unit_bad = 1'b0;
                if (last) close_unit(16'h0000, 1'b1, 1'b1);
            end
        end else begin
            if ((b & CONT_MASK) != CONT_TAG) unit_bad = 1'b1;
            unit_acc  = {unit_acc[9:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0) close_unit(unit_acc, unit_bad, last);
            else if (last) close_unit(16'h0000, 1'b1, 1'b1);
        end
    endtask

    // ---------------- driving ----------------

    // Offer one byte item; returns in the step it was accepted, valid left high
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, last);
        items_sent++;
    endtask

    // Stop offering and wait until every expected unit is out and the pipe is quiet
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_units.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_limit = value;
    endtask

    // One string of mostly well-formed characters with some broken ones mixed in
    task automatic send_random_string();
        int          n_chars;
        int          len;
        int          pick;
        int          bad_pos;
        int          n_cont;
        bit          done;
        logic [7:0]  lead;

        str_bytes.delete();
        n_chars = $urandom_range(1, 8);
        done    = 1'b0;
        for (int c = 0; c < n_chars && !done; c++) begin
            len = $urandom_range(1, 6);
            case (len)
                1: lead = 8'($urandom_range(0, 127));
                2: lead = LEAD2_MIN | 8'($urandom_range(0, 31));
                3: lead = LEAD3_MIN | 8'($urandom_range(0, 15));
                4: lead = LEAD4_MIN | 8'($urandom_range(0, 7));
                5: lead = LEAD5_MIN | 8'($urandom_range(0, 3));
                default: lead = LEAD6_MIN | 8'($urandom_range(0, 3));
            endcase
            pick    = $urandom_range(0, 99);
            bad_pos = (pick >= 72 && pick < 82 && len > 1) ? $urandom_range(1, len - 1) : 0;
            if (pick < 82) begin
                // complete sequence, possibly with one bad continuation
                str_bytes.push_back(lead);
                for (int k = 1; k < len; k++) begin
                    if (k == bad_pos) str_bytes.push_back(8'($urandom_range(0, 255)));
                    else str_bytes.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                end
            end else if (pick < 88) begin
                // string cut inside a sequence
                str_bytes.push_back(lead);
                n_cont = (len > 1) ? $urandom_range(0, len - 2) : 0;
                for (int k = 0; k < n_cont; k++)
                    str_bytes.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                done = 1'b1;
            end else if (pick < 94) begin
                str_bytes.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
            end else begin
                str_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (str_bytes[i])
            send_byte(str_bytes[i], (i == str_bytes.size() - 1));
    endtask

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        got = {m_tuser, m_tdata};
        if (m_tvalid && m_tready) begin
            if (pending_units.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: unit %h valid %b bad %b end %0d",
                             got.code_unit, got.unit_valid, got.malformed, got.end_kind);
            end else begin
                want = pending_units.pop_front();
                if (got.code_unit !== want.code_unit || got.unit_valid !== want.unit_valid ||
                    got.malformed !== want.malformed || got.end_kind !== want.end_kind) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: expected unit %h valid %b bad %b end %0d, ",
                               want.code_unit, want.unit_valid, want.malformed,
                               want.end_kind);
                        $display("got unit %h valid %b bad %b end %0d",
                                 got.code_unit, got.unit_valid, got.malformed,
                                 got.end_kind);
                    end
                end
            end
        end
        // long hold-off takes priority over random stalls
        if (hold_req && !hold_started) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES - 1;
            m_tready     <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Watchdog: no item moving on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_count <= 0;
        else quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("timeout: no item accepted for %0d cycles", QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_char_lengths();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // six-byte sequence with the top lead value, all payload bits set
        send_byte(8'hFF, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_malformed_input();
        // bad continuation still completes the sequence
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b1);
        // string ends inside a sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // lead byte is the last byte
        send_byte(8'hC3, 1'b1);
        // stray continuation, then the rest is discarded
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        // stray continuation as last byte; next byte starts fresh
        send_byte(8'hBF, 1'b1);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic test_capacity_limit();
        write_capacity(16'h0000);
        send_byte(8'h41, 1'b1);
        write_capacity(16'h0002);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(8'h44, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        write_capacity(CAP_RESET);
    endtask

    task automatic test_backpressure();
        int unsigned target;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        target       = items_sent + 80;
        hold_req     = 1'b1;
        while (items_sent < target) send_random_string();
        drain_results();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int unsigned target;
        int unsigned next_cfg;
        logic [15:0] cap;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        target       = items_sent + PHASE_ITEMS;
        next_cfg     = items_sent + CFG_INTERVAL;
        while (items_sent < target) begin
            send_random_string();
            if (items_sent >= next_cfg) begin
                case ($urandom_range(0, 5))
                    0: cap = 16'h0000;
                    1: cap = 16'($urandom_range(1, 4));
                    2: cap = CAP_RESET;
                    3: cap = 16'($urandom_range(0, 65535));
                    default: cap = 16'($urandom_range(2, 12));
                endcase
                write_capacity(cap);
                next_cfg = items_sent + CFG_INTERVAL;
            end
        end
    endtask

    initial begin
        cap_limit = CAP_RESET;
        clear_string();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_char_lengths();
        test_malformed_input();
        test_capacity_limit();
        test_backpressure();
        test_random_traffic(26, 53);
        test_random_traffic(53, 26);
        test_random_traffic(0, 0);

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_units.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
